// ----- rtl/tpd_pkg.sv -----
// Shared types and constants for the three-point derivative core.
package tpd_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COMBO_W      = SAMPLE_WIDTH + 3;   // holds 8 * full-scale sample
    localparam int SCALE_W      = 24;                 // signed Q8.16 scale 0.5/h
    localparam int PROD_W       = SCALE_W + COMBO_W;
    localparam int DERIV_W      = 32;
    localparam int MAX_RESULTS  = 3;
    localparam int SLOT_W       = 2;                  // indexes and counts result slots
    localparam int CNT_W        = 2;                  // saturating sample count

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_HALF_INV_STEP = REG_IDX_W'(0);
    localparam logic [SCALE_W-1:0] HALF_INV_STEP_RST = SCALE_W'(32768);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_ZERO_STEP = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [DERIV_W-1:0] derivative;
        t_status                   status;
        logic                      last_result;
    } t_out_item;

    // Pending results of one accepted sample, in emission order
    typedef struct packed {
        logic                                 valid;
        logic [MAX_RESULTS-1:0][COMBO_W-1:0]  combo;
        logic [SLOT_W-1:0]                    count;
        t_status                              status;
        logic                                 last;
    } t_job;

endpackage

// ----- rtl/tpd_cfg.sv -----
// APB-style register file holding the derivative scale.
module tpd_cfg import tpd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    output logic signed [SCALE_W-1:0]  o_half_inv_step
);

    logic [SCALE_W-1:0]   r_half_inv_step;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_write;

    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_write   = psel && penable && pwrite && pready
                       && (w_reg_idx == REG_HALF_INV_STEP);

    // Capture the scale on the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_inv_step <= HALF_INV_STEP_RST;
        end else if (w_write) begin
            r_half_inv_step <= pwdata[SCALE_W-1:0];
        end
    end

    // Read back sign-extended; unmapped addresses read zero
    always_comb begin
        if (w_reg_idx == REG_HALF_INV_STEP) begin
            prdata = {{(PDATA_W-SCALE_W){r_half_inv_step[SCALE_W-1]}}, r_half_inv_step};
        end else begin
            prdata = '0;
        end
    end

    assign pready          = 1'b1;
    assign o_half_inv_step = $signed(r_half_inv_step);

endmodule

// ----- rtl/tpd_front.sv -----
// Sample history, vector tracking and difference terms for each accepted sample.
module tpd_front import tpd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_item,
    input  logic signed [SCALE_W-1:0]  i_half_inv_step,
    input  logic                       i_job_pop,
    output t_job                       o_job
);

    logic signed [SAMPLE_WIDTH-1:0] r_p1;
    logic signed [SAMPLE_WIDTH-1:0] r_p2;
    logic [CNT_W-1:0]               r_cnt;
    t_job                           r_job;
    t_job                           n_job;

    logic                     w_accept;
    logic                     w_last;
    logic signed [COMBO_W-1:0] w_y;
    logic signed [COMBO_W-1:0] w_p1;
    logic signed [COMBO_W-1:0] w_p2;
    logic signed [COMBO_W-1:0] w_end_first;
    logic signed [COMBO_W-1:0] w_central;
    logic signed [COMBO_W-1:0] w_end_last;

    assign o_in_ready = !r_job.valid || i_job_pop;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = i_in_item.last_sample;

    // Extend samples to the combination width
    assign w_y  = {{(COMBO_W-SAMPLE_WIDTH){i_in_item.sample[SAMPLE_WIDTH-1]}}, i_in_item.sample};
    assign w_p1 = {{(COMBO_W-SAMPLE_WIDTH){r_p1[SAMPLE_WIDTH-1]}}, r_p1};
    assign w_p2 = {{(COMBO_W-SAMPLE_WIDTH){r_p2[SAMPLE_WIDTH-1]}}, r_p2};

    // One-sided ends and central difference
    assign w_end_first = (w_p1 <<< 2) - w_y - ((w_p2 <<< 1) + w_p2);
    assign w_central   = w_y - w_p2;
    assign w_end_last  = ((w_y <<< 1) + w_y) - (w_p1 <<< 2) + w_p2;

    // Build the result list for this sample
    always_comb begin
        n_job        = '0;
        n_job.status = ST_OK;
        n_job.last   = w_last;
        if (r_cnt < CNT_W'(2)) begin
            if (w_last) begin
                n_job.valid  = 1'b1;
                n_job.count  = SLOT_W'(1);
                n_job.status = ST_TOO_SHORT;
            end
        end else if (i_half_inv_step != '0) begin
            n_job.valid = 1'b1;
            if (r_cnt == CNT_W'(2)) begin
                n_job.combo[0] = w_end_first;
                n_job.combo[1] = w_central;
                n_job.combo[2] = w_end_last;
                n_job.count    = SLOT_W'(2) + {{(SLOT_W-1){1'b0}}, w_last};
            end else begin
                n_job.combo[0] = w_central;
                n_job.combo[1] = w_end_last;
                n_job.count    = SLOT_W'(1) + {{(SLOT_W-1){1'b0}}, w_last};
            end
        end else if (w_last) begin
            n_job.valid  = 1'b1;
            n_job.count  = SLOT_W'(1);
            n_job.status = ST_ZERO_STEP;
        end
    end

    // Advance history, clear at end of vector, hold pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1        <= '0;
            r_p2        <= '0;
            r_cnt       <= '0;
            r_job.valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_job <= n_job;
                if (w_last) begin
                    r_p1  <= '0;
                    r_p2  <= '0;
                    r_cnt <= '0;
                end else begin
                    r_p2 <= r_p1;
                    r_p1 <= i_in_item.sample;
                    if (r_cnt != CNT_W'(3)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
            end else if (i_job_pop) begin
                r_job.valid <= 1'b0;
            end
        end
    end

    assign o_job = r_job;

    // A pending job always carries at least one result
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job.valid |-> (r_job.count != '0))
        else $error("pending job with no results");

    // History is cleared after the last sample of a vector
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_cnt == '0 && r_p1 == '0 && r_p2 == '0))
        else $error("history not cleared at end of vector");

endmodule

// ----- rtl/tpd_emit.sv -----
// Result sequencer: scales each difference term, saturates, and drives the result register.
module tpd_emit import tpd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_job                       i_job,
    input  logic signed [SCALE_W-1:0]  i_half_inv_step,
    output logic                       o_job_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out_item
);

    logic [SLOT_W-1:0]          r_idx;
    logic                       r_out_valid;
    t_out_item                  r_out_item;
    t_out_item                  n_out_item;

    logic                       w_adv;
    logic                       w_final;
    logic signed [COMBO_W-1:0]  w_combo;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_ovf;

    assign w_adv     = i_job.valid && (!r_out_valid || i_out_ready);
    assign w_final   = (r_idx == (i_job.count - SLOT_W'(1)));
    assign o_job_pop = w_adv && w_final;

    // Scale the selected term; result is already Q.16
    assign w_combo = $signed(i_job.combo[r_idx]);
    assign w_prod  = PROD_W'(i_half_inv_step) * PROD_W'(w_combo);

    // Overflow when the bits above the 32-bit result disagree with its sign
    assign w_ovf = (w_prod[PROD_W-1:DERIV_W-1] != {(PROD_W-DERIV_W+1){1'b0}})
                && (w_prod[PROD_W-1:DERIV_W-1] != {(PROD_W-DERIV_W+1){1'b1}});

    always_comb begin
        n_out_item.status      = i_job.status;
        n_out_item.last_result = i_job.last && w_final;
        if (w_ovf) begin
            n_out_item.derivative = w_prod[PROD_W-1]
                ? {1'b1, {(DERIV_W-1){1'b0}}}
                : {1'b0, {(DERIV_W-1){1'b1}}};
        end else begin
            n_out_item.derivative = w_prod[DERIV_W-1:0];
        end
    end

    // Step through the job's slots and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_out_item  <= n_out_item;
                r_idx       <= w_final ? '0 : r_idx + SLOT_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Slot index stays within the job
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.valid |-> (r_idx < i_job.count))
        else $error("result slot index past job count");

    // Error results carry zero and close the vector
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status != ST_OK)
            |-> (r_out_item.derivative == '0 && r_out_item.last_result))
        else $error("error result not zero or not final");

    // Index returns to zero whenever no job is pending
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job.valid |-> (r_idx == '0))
        else $error("slot index left nonzero between jobs");

endmodule

// ----- rtl/three_point_derivative_core.sv -----
// Top level of the three-point finite-difference derivative core.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_in_item  (sample, last_sample)
//   output    out        o_out_valid / i_out_ready  o_out_item (derivative, status, last_result)
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata (half_inv_step)
//
// A sample releasing at most one result is accepted every cycle while the output is not
// stalled. A sample releasing two or three results (the third sample of a vector, or a last
// sample after two or more others) keeps o_in_ready low until its last result is loaded,
// one result per cycle from the shared scale multiplier while the output is not stalled.
// A sample's first result is held in the job register and then in the result register.
// Reset is synchronous; no clearing pass is needed after it.
// Output stalls back up through the result register and job register to o_in_ready.
module three_point_derivative_core import tpd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic signed [SCALE_W-1:0] w_half_inv_step;
    t_job                      w_job;
    logic                      w_job_pop;

    // Scale register
    tpd_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_half_inv_step (w_half_inv_step)
    );

    // Sample history and difference terms
    tpd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_item       (i_in_item),
        .i_half_inv_step (w_half_inv_step),
        .i_job_pop       (w_job_pop),
        .o_job           (w_job)
    );

    // Scaling, saturation and result register
    tpd_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_job),
        .i_half_inv_step (w_half_inv_step),
        .o_job_pop       (w_job_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item)
    );

endmodule
